// ----- design/serial_frame_receiver_unit_macros.svh -----
// assertion macros for the serial frame receiver checker
// no dependencies; included by the checker file only
`ifndef SERIAL_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define SFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("serial frame receiver check failed");

// next-cycle implication, sampled on aclk, off during reset
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("serial frame receiver check failed");

`endif

// ----- design/sfr_pkg.sv -----
// shared constants and controller/datapath interface types
// for the serial frame receiver; no dependencies
package sfr_pkg;

    localparam int FRAME_DEPTH = 64;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIM = 2'd3;

    // input word kinds carried on s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_RESET   = 8'hAA;
    localparam logic [LEN_W-1:0]  MIN_LEN_RESET  = 6'd1;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET  = 6'd63;
    localparam logic [BYTE_W-1:0] IDLE_LIM_RESET = 8'd5;
    localparam logic [BYTE_W-1:0] IDLE_MAX       = 8'hFF;

    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic rd_en;    // read frame store at drain index
        logic advance;  // output word taken, step drain index
    } sfr_cmd_t;

    typedef struct packed {
        logic emit_now; // current input word completes a good frame
        logic rd_last;  // drain index is at the final frame byte
    } sfr_sts_t;

endpackage

// ----- design/serial_frame_receiver_unit.sv -----
// top level of the serial frame receiver: stream ports, config port,
// controller and datapath instances; uses sfr_pkg, sfr_controller, sfr_datapath
//
//  channel   direction  payload
//  s_        in         tuser: op (0 byte, 1 tick); tdata[7:0]: rx_byte
//  m_        out        tdata[7:0]: frame_byte, [13:8]: byte_index; tlast: last
//  cfg_      in         index 0 header, 1 min length, 2 max length, 3 idle limit
//
// input words are taken one word per cycle between frames, while s_tready is high.
// after the word that completes a good frame, the frame of L+1 bytes drains byte
// by byte through a store read and then the output register; no input is taken then.
// a stalled output holds its word; drain resumes when m_tready returns.
// synchronous reset clears control state; the frame store needs no clearing.
module serial_frame_receiver_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sfr_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [7:0] frame_byte, [13:8] byte_index
    output logic                              m_tlast
);
    import sfr_pkg::*;

    sfr_cmd_t          cmd;
    sfr_sts_t          sts;
    logic [BYTE_W-1:0] out_byte;
    logic [IDX_W-1:0]  out_index;

    sfr_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sfr_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_byte  (out_byte),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {(OUT_TDATA_W - IDX_W - BYTE_W)'(0), out_index, out_byte};

endmodule

// ----- design/sfr_datapath.sv -----
// datapath: config registers, idle counter, frame assembly, checksum,
// frame store memory and drain output registers; uses sfr_pkg
module sfr_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_op,
    input  logic [sfr_pkg::BYTE_W-1:0]      in_byte,
    input  sfr_pkg::sfr_cmd_t               cmd,
    output sfr_pkg::sfr_sts_t               sts,
    output logic [sfr_pkg::BYTE_W-1:0]      out_byte,
    output logic [sfr_pkg::IDX_W-1:0]       out_index,
    output logic                            out_last
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] header_reg;
    logic [LEN_W-1:0]  min_len_reg;
    logic [LEN_W-1:0]  max_len_reg;
    logic [BYTE_W-1:0] idle_lim_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] idle_reg, idle_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [BYTE_W-1:0] rd_data_reg;

    logic [BYTE_W-1:0] store_mem [FRAME_DEPTH];

    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  len_plus;
    logic [BYTE_W-1:0] sum_add;
    logic              len_bad;
    logic              byte_emit;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              take_byte;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg   <= HEADER_RESET;
            min_len_reg  <= MIN_LEN_RESET;
            max_len_reg  <= MAX_LEN_RESET;
            idle_lim_reg <= IDLE_LIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HEADER:   header_reg   <= cfg_data;
                REG_MIN_LEN:  min_len_reg  <= cfg_data[LEN_W-1:0];
                REG_MAX_LEN:  max_len_reg  <= cfg_data[LEN_W-1:0];
                REG_IDLE_LIM: idle_lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a long silence restarts reception before this byte is looked at
    assign cnt_eff  = (idle_reg > idle_lim_reg) ? '0 : count_reg;
    assign cnt_inc  = cnt_eff + CNT_W'(1);
    assign len_plus = CNT_W'(len_reg) + CNT_W'(1);
    assign sum_add  = sum_reg + in_byte;
    assign len_bad  = (in_byte > BYTE_W'(max_len_reg)) || (in_byte < BYTE_W'(min_len_reg))
                      || (in_byte > BYTE_W'(FRAME_DEPTH - 1));
    assign take_byte = cmd.accept && (in_op == OP_BYTE);

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        idle_next  = idle_reg;
        byte_emit  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = cnt_eff[ADDR_W-1:0];

        priority if (cnt_eff == '0) begin
            if (in_byte == header_reg) begin
                wr_en      = 1'b1;
                sum_next   = '0;
                count_next = CNT_W'(1);
            end else begin
                count_next = '0;
            end
        end else if (cnt_eff == CNT_W'(1)) begin
            if (len_bad) begin
                count_next = '0;
            end else begin
                wr_en    = 1'b1;
                len_next = in_byte[LEN_W-1:0];
                sum_next = in_byte;
                if (in_byte <= BYTE_W'(1)) begin
                    // length zero or one finishes right at the length byte
                    count_next = '0;
                    byte_emit  = (in_byte == '0);
                    if (in_byte == '0) begin
                        sum_next = '0;
                    end
                end else begin
                    count_next = CNT_W'(2);
                end
            end
        end else if (cnt_eff >= CNT_W'(FRAME_DEPTH)) begin
            count_next = '0;
        end else begin
            wr_en    = 1'b1;
            sum_next = sum_add;
            if (cnt_inc >= len_plus) begin
                count_next = '0;
                byte_emit  = (sum_add == '0);
            end else begin
                count_next = cnt_inc;
            end
        end

        if (in_op == OP_TICK) begin
            idle_next = (idle_reg != IDLE_MAX) ? idle_reg + BYTE_W'(1) : idle_reg;
        end else begin
            idle_next = '0;
        end
    end

    assign sts.emit_now = (in_op == OP_BYTE) && byte_emit;
    assign sts.rd_last  = (rd_idx_reg == ADDR_W'(len_reg));

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.accept && sts.emit_now) begin
            rd_idx_next = '0;
        end else if (cmd.advance) begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            idle_reg   <= '0;
            sum_reg    <= '0;
            len_reg    <= '0;
            rd_idx_reg <= '0;
        end else begin
            rd_idx_reg <= rd_idx_next;
            if (cmd.accept) begin
                idle_reg <= idle_next;
            end
            if (take_byte) begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                len_reg   <= len_next;
            end
        end
    end

    // frame store: at most one write per byte word, registered read for draining
    always_ff @(posedge aclk) begin
        if (take_byte && wr_en) begin
            store_mem[wr_addr] <= in_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    assign out_byte  = rd_data_reg;
    assign out_index = IDX_W'(rd_idx_reg);
    assign out_last  = sts.rd_last;

endmodule

// ----- design/sfr_controller.sv -----
// controller: one-hot state machine that takes input words and walks
// the drain of a verified frame; uses sfr_pkg
module sfr_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output sfr_pkg::sfr_cmd_t cmd,
    input  sfr_pkg::sfr_sts_t sts
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCEPT = 3'b001,
        ST_READ   = 3'b010,
        ST_SHOW   = 3'b100
    } sfr_state_t;

    sfr_state_t state_reg, state_next;

    assign s_tready    = (state_reg == ST_ACCEPT);
    assign m_tvalid    = (state_reg == ST_SHOW);
    assign cmd.accept  = s_tvalid && s_tready;
    assign cmd.rd_en   = (state_reg == ST_READ);
    assign cmd.advance = m_tvalid && m_tready && !sts.rd_last;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCEPT: begin
                if (cmd.accept && sts.emit_now) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (m_tready) begin
                    state_next = sts.rd_last ? ST_ACCEPT : ST_READ;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/sfr_checker.sv -----
// port-level checks for the serial frame receiver, bound to the top level
// depends on serial_frame_receiver_unit_macros.svh
`include "serial_frame_receiver_unit_macros.svh"

module sfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // no input is taken while a frame drains
    `SFR_ASSERT_NOW(a_drain_blocks_input, m_tvalid, !s_tready)

    // a mid-frame word taken leads to the next store read, not to input
    `SFR_ASSERT_NEXT(a_mid_frame_holds, m_tvalid && m_tready && !m_tlast, !s_tready && !m_tvalid)

    // the final word of a frame reopens the input side
    `SFR_ASSERT_NEXT(a_last_reopens, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

    // a tick never starts a frame drain
    `SFR_ASSERT_NEXT(a_tick_no_output, s_tvalid && s_tready && s_tuser, !m_tvalid && s_tready)

    // a stalled output word holds
    `SFR_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind serial_frame_receiver_unit sfr_checker u_sfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/sfr_frame_checker.sv -----
// frame checker for serial_frame_receiver_unit: watches config, input and output
// words, predicts the emitted frame bytes and compares them; uses sfr_pkg
module sfr_frame_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  logic                            s_tuser,   // [0] op
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sfr_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_index
    input  logic                            m_tlast,
    output int                              mismatch_count,
    output int                              words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] fbyte;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } frame_word_t;

    frame_word_t frame_bytes_due[$];

    logic [BYTE_W-1:0] hdr_val;
    logic [LEN_W-1:0]  len_min;
    logic [LEN_W-1:0]  len_max;
    logic [BYTE_W-1:0] idle_lim;

    logic [CNT_W-1:0]  held;
    logic [BYTE_W-1:0] frame_mem [FRAME_DEPTH];
    logic [BYTE_W-1:0] idle_cnt;
    logic [BYTE_W-1:0] sum;
    logic [LEN_W-1:0]  flen;

    function automatic void close_frame();
        frame_word_t w;
        held = '0;
        if (sum == '0) begin
            for (int k = 0; k <= int'(flen); k++) begin
                w.fbyte = frame_mem[k];
                w.idx   = IDX_W'(k);
                w.last  = (k == int'(flen));
                frame_bytes_due.push_back(w);
            end
        end
    endfunction

    function automatic void deframe_word(input logic op, input logic [BYTE_W-1:0] b);
        if (op == OP_TICK) begin
            if (idle_cnt != IDLE_MAX)
                idle_cnt++;
            return;
        end
        // a long enough silence throws away a partial frame
        if (idle_cnt > idle_lim)
            held = '0;
        idle_cnt = '0;

        if (held == '0) begin
            if (b == hdr_val) begin
                frame_mem[0] = b;
                sum = '0;
                held = CNT_W'(1);
            end
            return;
        end

        if (held == CNT_W'(1)) begin
            if (b > {2'b00, len_max} || b < {2'b00, len_min} || int'(b) > FRAME_DEPTH - 1) begin
                held = '0;
                return;
            end
            frame_mem[1] = b;
            flen = b[LEN_W-1:0];
            sum = b;
            held = CNT_W'(2);
            if (flen <= LEN_W'(1)) begin
                if (flen == '0)
                    sum = '0;
                close_frame();
            end
            return;
        end

        if (int'(held) >= FRAME_DEPTH) begin
            held = '0;
            return;
        end
        frame_mem[held[ADDR_W-1:0]] = b;
        sum = sum + b;
        held = held + CNT_W'(1);
        if (int'(held) >= int'(flen) + 1)
            close_frame();
    endfunction

    always @(posedge aclk) begin
        frame_word_t want;
        if (!aresetn) begin
            hdr_val  = HEADER_RESET;
            len_min  = MIN_LEN_RESET;
            len_max  = MAX_LEN_RESET;
            idle_lim = IDLE_LIM_RESET;
            held     = '0;
            idle_cnt = '0;
            sum      = '0;
            flen     = '0;
            frame_bytes_due.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_HEADER:   hdr_val  = cfg_data;
                    REG_MIN_LEN:  len_min  = cfg_data[LEN_W-1:0];
                    REG_MAX_LEN:  len_max  = cfg_data[LEN_W-1:0];
                    REG_IDLE_LIM: idle_lim = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                deframe_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("unexpected output word: frame_byte %0h byte_index %0d last %0b",
                           m_tdata[7:0], m_tdata[13:8], m_tlast);
                    mismatch_count++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (m_tdata[7:0] !== want.fbyte) begin
                        $error("frame_byte mismatch: expected %0h, actual %0h",
                               want.fbyte, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[13:8] !== want.idx) begin
                        $error("byte_index mismatch: expected %0d, actual %0d",
                               want.idx, m_tdata[13:8]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
        words_due = frame_bytes_due.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top for serial_frame_receiver_unit: clock, reset, config writes,
// byte/tick stimulus and output back-pressure; uses sfr_pkg and sfr_frame_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;   // [7:0] rx_byte
    logic                   s_tuser;   // [0] op
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [7:0] frame_byte, [13:8] byte_index
    logic                   m_tlast;

    int mismatch_count;
    int words_due;
    int words_sent;
    int idle_pct;
    int stall_pct;
    bit hold_req;

    serial_frame_receiver_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sfr_frame_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int hold_cycles_left;
        bit hold_done;
        hold_cycles_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_cycles_left = 400;
            end
            if (hold_cycles_left > 0) begin
                hold_cycles_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(OP_TICK, 8'($urandom));
    endtask

    // a few ticks between bytes now and then, never more than max_ticks
    task automatic tick_gap(input int max_ticks);
        if (max_ticks > 0 && $urandom_range(3) == 0)
            send_ticks($urandom_range(max_ticks, 0));
    endtask

    task automatic send_frame(input logic [7:0] hdr, input int len, input bit bad_sum,
                              input int max_ticks);
        logic [7:0] acc;
        logic [7:0] pay;
        send_word(OP_BYTE, hdr);
        tick_gap(max_ticks);
        send_word(OP_BYTE, 8'(len));
        acc = 8'(len);
        for (int i = 1; i < len; i++) begin
            tick_gap(max_ticks);
            if (i == len - 1) begin
                pay = 8'h00 - acc;
                if (bad_sum)
                    pay = pay + 8'($urandom_range(255, 1));
            end else begin
                pay = 8'($urandom);
            end
            acc = acc + pay;
            send_word(OP_BYTE, pay);
        end
    endtask

    task automatic random_frame(input logic [7:0] hdr, input int lo, input int hi,
                                input int lim);
        int kind;
        int len;
        int max_ticks;
        max_ticks = (lim > 3) ? 3 : lim;
        kind = $urandom_range(99);
        if ($urandom_range(9) == 0 || hi - lo <= 6)
            len = $urandom_range(hi, lo);
        else
            len = $urandom_range(lo + 6, lo);
        if (kind < 68) begin
            send_frame(hdr, len, 1'b0, max_ticks);
        end else if (kind < 80) begin
            send_frame(hdr, len, 1'b1, max_ticks);
        end else if (kind < 88) begin
            send_word(OP_BYTE, hdr);
            if (lim > 20) begin
                // length byte beyond the store
                send_word(OP_BYTE, 8'($urandom_range(255, 64)));
            end else begin
                // frame cut short by a silence
                send_word(OP_BYTE, 8'(len));
                repeat ($urandom_range(2, 0)) send_word(OP_BYTE, 8'($urandom));
                send_ticks(lim + 1);
            end
        end else if (kind < 94) begin
            repeat ($urandom_range(4, 1))
                send_word(OP_BYTE, ($urandom_range(3) == 0) ? hdr : 8'($urandom));
        end else begin
            send_ticks($urandom_range(lim + 2, 1));
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] hdr, input logic [5:0] len_lo,
                              input logic [5:0] len_hi, input logic [7:0] lim);
        put_reg(REG_HEADER, hdr);
        put_reg(REG_MIN_LEN, {2'b00, len_lo});
        put_reg(REG_MAX_LEN, {2'b00, len_hi});
        put_reg(REG_IDLE_LIM, lim);
        cfg_wr_en <= 1'b0;
    endtask

    // sender pauses until all predicted frame bytes are out, then lets the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (words_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        int target;
        logic [7:0] rand_hdr;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tuser   = OP_BYTE;
        s_tdata   = '0;
        hold_req  = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        words_sent = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: header 0xaa, lengths 1..63, idle limit 5
        send_word(OP_BYTE, 8'h02);              // not a header, dropped
        send_frame(8'hAA, 2, 1'b0, 0);
        send_frame(8'hAA, 2, 1'b1, 0);
        send_word(OP_BYTE, 8'hAA);
        send_word(OP_BYTE, 8'h00);              // length below minimum
        send_word(OP_BYTE, 8'hAA);
        send_word(OP_BYTE, 8'hFF);              // length past the store
        send_frame(8'hAA, 1, 1'b0, 0);          // sum is the length, never good
        send_word(OP_BYTE, 8'hAA);
        send_word(OP_BYTE, 8'h03);
        send_ticks(6);                          // silence over the limit restarts
        send_frame(8'hAA, 2, 1'b0, 0);
        wait_drained();

        // header 0x00, zero length allowed, short frames
        idle_pct = 82;
        set_config(8'h00, 6'd0, 6'd63, 8'd6);
        send_frame(8'h00, 0, 1'b0, 0);          // header only
        target = words_sent + 8;
        while (words_sent < target)
            random_frame(8'h00, 0, 6, 6);
        wait_drained();

        // only full-size frames, no tolerance for silence, output held off
        idle_pct = 0;
        stall_pct = 82;
        set_config(8'hFF, 6'd63, 6'd63, 8'd0);
        hold_req = 1'b1;
        send_frame(8'hFF, 63, 1'b0, 0);
        send_ticks(2);                          // offered while the frame is held
        wait_drained();

        // min above max: every frame refused
        idle_pct = 22;
        stall_pct = 22;
        rand_hdr = 8'($urandom);
        set_config(rand_hdr, 6'd63, 6'd1, 8'd5);
        target = words_sent + 6;
        while (words_sent < target)
            random_frame(rand_hdr, 0, 6, 5);
        wait_drained();

        set_config(8'hA5, 6'd2, 6'd10, 8'd3);
        target = words_sent + 10;
        while (words_sent < target)
            random_frame(8'hA5, 2, 10, 3);
        wait_drained();

        repeat (20) @(negedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
